// ===== src/pre_pkg.sv =====
// Shared types, character codes and register indexes of the printable run extractor.
// No dependencies; imported by the cell, the cell chain and the top level.
package pre_pkg;

   localparam int MIN_W  = 7;   // width of the min_length register
   localparam int BYTE_W = 8;
   localparam int OFF_W  = 32;
   localparam int IDX_W  = 2;

   localparam logic [BYTE_W-1:0] CHAR_FF    = 8'h0C;
   localparam logic [BYTE_W-1:0] CHAR_NL    = 8'h0A;
   localparam logic [BYTE_W-1:0] CHAR_DEL   = 8'h7F;
   localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CHAR_HIGH  = 8'h80;

   localparam logic [IDX_W-1:0] CSR_MIN_LENGTH  = 2'd0;
   localparam logic [IDX_W-1:0] CSR_SHOW_OFFSET = 2'd1;
   localparam logic [IDX_W-1:0] CSR_BASE_OFFSET = 2'd2;

   localparam logic KIND_CHAR = 1'b0;
   localparam logic KIND_END  = 1'b1;

   // Per-cycle commands from the control logic to the row of cells.
   typedef struct packed {
      logic wr_en;   // store wr_data in the addressed cell
      logic load;    // copy every stored byte into its read-out stage
      logic shift;   // move the read-out stages one cell toward the head
   } pre_chain_ctrl_type;

   function automatic logic is_clean(input logic [BYTE_W-1:0] b);
      logic ok;
      if (b == CHAR_FF) begin
         ok = 1'b1;
      end else if (b == CHAR_NL || b == CHAR_DEL) begin
         ok = 1'b0;
      end else begin
         ok = !(b > CHAR_HIGH || b < CHAR_SPACE);
      end
      return ok;
   endfunction

endpackage

// ===== src/pre_cell.sv =====
// One cell of the held-byte row: a stored byte plus a read-out stage.
// Depends on pre_pkg for the control struct.
module pre_cell
   import pre_pkg::*;
#(
   parameter int ADDR_W = 6,
   parameter int INDEX  = 0
) (
   input  logic                clock,
   input  pre_chain_ctrl_type  ctrl,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  logic [BYTE_W-1:0]   wr_data,
   input  logic [BYTE_W-1:0]   shift_in,
   output logic [BYTE_W-1:0]   shift_out
);

   logic [BYTE_W-1:0] held_ff;
   logic [BYTE_W-1:0] held_in;
   logic [BYTE_W-1:0] out_ff;
   logic [BYTE_W-1:0] out_in;

   always_comb begin
      held_in = held_ff;
      if (ctrl.wr_en && wr_addr == ADDR_W'(INDEX)) begin
         held_in = wr_data;
      end
      priority if (ctrl.load) begin
         out_in = held_ff;
      end else if (ctrl.shift) begin
         out_in = shift_in;
      end else begin
         out_in = out_ff;
      end
   end

   always_ff @(posedge clock) begin
      held_ff <= held_in;
      out_ff  <= out_in;
   end

   assign shift_out = out_ff;

endmodule

// ===== src/pre_chain.sv =====
// Row of held-byte cells; the read-out stages shift toward cell 0, the head.
// Depends on pre_pkg and pre_cell.
module pre_chain
   import pre_pkg::*;
#(
   parameter int NUM_CELLS = 63,
   parameter int ADDR_W    = 6
) (
   input  logic                clock,
   input  pre_chain_ctrl_type  ctrl,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  logic [BYTE_W-1:0]   wr_data,
   output logic [BYTE_W-1:0]   head_out
);

   logic [BYTE_W-1:0] link [NUM_CELLS+1];

   assign link[NUM_CELLS] = '0;

   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      pre_cell #(
         .ADDR_W (ADDR_W),
         .INDEX  (i)
      ) u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .wr_addr   (wr_addr),
         .wr_data   (wr_data),
         .shift_in  (link[i+1]),
         .shift_out (link[i])
      );
   end

   assign head_out = link[0];

endmodule

// ===== src/printable_run_extractor_unit.sv =====
// Printable run extractor: takes one byte item per cycle, except while it flushes or
// its result register is held, and reports runs of printable bytes of at least
// min_length as character items followed by an end-of-string item.
// Depends on pre_pkg, pre_chain and pre_cell.
//
// A byte that passes through, ends a run, or is held is accepted whenever the result
// register is free or being taken in that cycle. The byte that brings a run to
// min_length (m, clipped to MAX_MIN_LEN) starts a flush: the m-1 held bytes leave the
// head of the cell row one per cycle while the result register is free or being taken,
// then the byte itself, and req_ready stays low until that byte is in the result
// register. The result register is the only output buffer: a stalled rsp_ready holds
// the input after at most one item. Bytes of a run past MAX_KEPT give no result but
// still advance the position. Held bytes have no reset; a flush after min_length was
// raised may emit bytes left over from earlier runs. Configuration writes are always
// taken and must only come while the block is idle.
module printable_run_extractor_unit
   import pre_pkg::*;
#(
   parameter int MAX_KEPT    = 510,
   parameter int MAX_MIN_LEN = 64
) (
   input  logic               clock,
   input  logic               reset,
   // input byte items
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [BYTE_W-1:0]  req_data_byte,
   input  logic               req_at_end,
   // result items
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_kind,
   output logic [BYTE_W-1:0]  rsp_char_out,
   output logic [OFF_W-1:0]   rsp_start_offset,
   output logic               rsp_last,
   // register writes
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [IDX_W-1:0]   csr_index,
   input  logic [OFF_W-1:0]   csr_wdata
);

   localparam int NUM_CELLS = (MAX_MIN_LEN > 1) ? MAX_MIN_LEN - 1 : 1;
   localparam int ADDR_W    = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
   localparam int RL_W      = $clog2(MAX_KEPT + 1);

   localparam logic ST_RUN   = 1'b0;
   localparam logic ST_FLUSH = 1'b1;

   // configuration
   logic [MIN_W-1:0] min_len_ff, min_len_in;
   logic             show_off_ff, show_off_in;
   logic [OFF_W-1:0] base_off_ff, base_off_in;

   // scan state
   logic [RL_W-1:0]  run_len_ff, run_len_in;
   logic [OFF_W-1:0] run_start_ff, run_start_in;
   logic [OFF_W-1:0] pos_ff, pos_in;
   logic             state_ff, state_in;
   logic [MIN_W-1:0] flush_cnt_ff, flush_cnt_in;
   logic [BYTE_W-1:0] flush_char_ff, flush_char_in;
   logic [OFF_W-1:0] flush_off_ff, flush_off_in;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_kind_ff, rsp_kind_in;
   logic [BYTE_W-1:0] rsp_char_ff, rsp_char_in;
   logic [OFF_W-1:0]  rsp_off_ff, rsp_off_in;
   logic              rsp_last_ff, rsp_last_in;

   // chain interface
   pre_chain_ctrl_type chain_ctrl;
   logic [BYTE_W-1:0]  head_byte;

   logic              out_free;
   logic              req_fire;
   logic              clean;
   logic [MIN_W-1:0]  m_eff;
   logic [RL_W-1:0]   m_ext;
   logic [RL_W-1:0]   new_len;
   logic [OFF_W-1:0]  start_sel;
   logic [OFF_W-1:0]  off_calc;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_RUN) && out_free;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign clean     = !req_at_end && is_clean(req_data_byte);
   assign m_eff     = (min_len_ff > MIN_W'(MAX_MIN_LEN)) ? MIN_W'(MAX_MIN_LEN) : min_len_ff;
   assign m_ext     = RL_W'(m_eff);
   assign new_len   = run_len_ff + RL_W'(1);
   // a run that is still empty starts (or ends) at the current position
   assign start_sel = (run_len_ff == '0) ? pos_ff : run_start_ff;
   assign off_calc  = show_off_ff ? base_off_ff + start_sel : '0;

   // register writes; unknown indexes drop
   always_comb begin
      min_len_in  = min_len_ff;
      show_off_in = show_off_ff;
      base_off_in = base_off_ff;
      if (csr_valid && csr_ready) begin
         if (csr_index == CSR_MIN_LENGTH) begin
            min_len_in = csr_wdata[MIN_W-1:0];
         end else if (csr_index == CSR_SHOW_OFFSET) begin
            show_off_in = csr_wdata[0];
         end else if (csr_index == CSR_BASE_OFFSET) begin
            base_off_in = csr_wdata;
         end
      end
   end

   // scan and result sequencing
   always_comb begin
      run_len_in    = run_len_ff;
      run_start_in  = run_start_ff;
      pos_in        = pos_ff;
      state_in      = state_ff;
      flush_cnt_in  = flush_cnt_ff;
      flush_char_in = flush_char_ff;
      flush_off_in  = flush_off_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_char_in   = rsp_char_ff;
      rsp_off_in    = rsp_off_ff;
      rsp_last_in   = rsp_last_ff;
      chain_ctrl    = '0;

      unique case (state_ff)
         ST_RUN: begin
            if (req_fire) begin
               if (clean) begin
                  run_start_in = start_sel;
                  pos_in       = pos_ff + OFF_W'(1);
                  if (run_len_ff < RL_W'(MAX_KEPT)) begin
                     run_len_in = new_len;
                     priority if (new_len < m_ext) begin
                        // hold the byte until the run is long enough
                        chain_ctrl.wr_en = 1'b1;
                     end else if (new_len == m_ext && m_eff > MIN_W'(1)) begin
                        // start the flush of the held bytes
                        chain_ctrl.load = 1'b1;
                        flush_cnt_in    = m_eff - MIN_W'(1);
                        flush_char_in   = req_data_byte;
                        flush_off_in    = off_calc;
                        state_in        = ST_FLUSH;
                     end else begin
                        // pass the byte straight through
                        rsp_valid_in = 1'b1;
                        rsp_kind_in  = KIND_CHAR;
                        rsp_char_in  = req_data_byte;
                        rsp_off_in   = off_calc;
                        rsp_last_in  = 1'b1;
                     end
                  end
               end else begin
                  if (run_len_ff >= m_ext) begin
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = KIND_END;
                     rsp_char_in  = '0;
                     rsp_off_in   = off_calc;
                     rsp_last_in  = 1'b1;
                  end
                  run_len_in = '0;
                  if (!req_at_end) begin
                     pos_in = pos_ff + OFF_W'(1);
                  end
               end
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_CHAR;
               rsp_off_in   = flush_off_ff;
               if (flush_cnt_ff != '0) begin
                  // emit the next held byte and advance the row
                  rsp_char_in      = head_byte;
                  rsp_last_in      = 1'b0;
                  chain_ctrl.shift = 1'b1;
                  flush_cnt_in     = flush_cnt_ff - MIN_W'(1);
               end else begin
                  // finish with the byte that completed the run
                  rsp_char_in = flush_char_ff;
                  rsp_last_in = 1'b1;
                  state_in    = ST_RUN;
               end
            end
         end
      endcase
   end

   pre_chain #(
      .NUM_CELLS (NUM_CELLS),
      .ADDR_W    (ADDR_W)
   ) u_chain (
      .clock    (clock),
      .ctrl     (chain_ctrl),
      .wr_addr  (run_len_ff[ADDR_W-1:0]),
      .wr_data  (req_data_byte),
      .head_out (head_byte)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         min_len_ff   <= MIN_W'(4);
         show_off_ff  <= 1'b0;
         base_off_ff  <= '0;
         run_len_ff   <= '0;
         run_start_ff <= '0;
         pos_ff       <= '0;
         state_ff     <= ST_RUN;
         flush_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         min_len_ff   <= min_len_in;
         show_off_ff  <= show_off_in;
         base_off_ff  <= base_off_in;
         run_len_ff   <= run_len_in;
         run_start_ff <= run_start_in;
         pos_ff       <= pos_in;
         state_ff     <= state_in;
         flush_cnt_ff <= flush_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      flush_char_ff <= flush_char_in;
      flush_off_ff  <= flush_off_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_char_ff   <= rsp_char_in;
      rsp_off_ff    <= rsp_off_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = rsp_kind_ff;
   assign rsp_char_out     = rsp_char_ff;
   assign rsp_start_offset = rsp_off_ff;
   assign rsp_last         = rsp_last_ff;

   // the final step of a flush always hands over the completing byte as the last item
   a_flush_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH && out_free && flush_cnt_ff == '0)
         |=> (rsp_valid && rsp_last && rsp_kind == KIND_CHAR && state_ff == ST_RUN))
      else $error("flush did not end with the completing byte");

   // no intermediate flush item carries the last flag
   a_flush_mid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FLUSH && out_free && flush_cnt_ff != '0)
         |=> (rsp_valid && !rsp_last && state_ff == ST_FLUSH))
      else $error("held byte emitted with last flag");

   // the kept length never passes its cap
   a_run_cap: assert property (@(posedge clock) disable iff (reset)
      run_len_ff <= RL_W'(MAX_KEPT))
      else $error("run length beyond cap");

   // an end-of-string item carries no character and closes its input item
   a_end_item: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_END) |-> (rsp_char_out == '0 && rsp_last))
      else $error("malformed end-of-string item");

endmodule
